### hdl/mkn_pkg.sv
package mkn_pkg;

   localparam int NODE_SLOTS_DEF = 16;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int ID_W     = 16;
   localparam int MAC_W    = 48;
   localparam int MTU_W    = 16;
   localparam int SPECS_W  = 64;

   // Node ids are handed out starting from this value.
   localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_LOOKUP_MAC = 2'd1,
      CMD_LOOKUP_ID  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXISTS    = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_WRITE,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [MAC_W-1:0]   mac;
      logic [MTU_W-1:0]   mtu;
      logic [SPECS_W-1:0] specs;
   } entry_type;

   typedef struct packed {
      status_type status;
      entry_type  entry;
   } result_type;

endpackage

### hdl/mac_keyed_node_table.sv
// A command scans the stored entries in slot order and stops at the first match; a miss, or
// a registration on a full table, ends after the last filled slot, and a new registration
// then writes its entry. An unused command code skips the scan and answers not found.
// The next request is taken in the cycle after the result is loaded into the output register.
// The scan rate is one stored entry per cycle, set by the single compare unit fed from
// the one read port of the entry RAM. Reset (synchronous) empties the table, sets the
// next node id to 1 and drops any pending result; entry storage itself is not cleared.
module mac_keyed_node_table
   import mkn_pkg::*;
#(
   parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [MAC_W-1:0]   req_mac_addr,
   input  logic [ID_W-1:0]    req_query_id,
   input  logic [MTU_W-1:0]   req_link_mtu,
   input  logic [SPECS_W-1:0] req_specs_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]    rsp_found_id,
   output logic [MAC_W-1:0]   rsp_found_mac,
   output logic [MTU_W-1:0]   rsp_found_mtu,
   output logic [SPECS_W-1:0] rsp_found_specs
);

   logic       res_valid;
   logic       res_take;
   result_type res;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   mkn_scan_ctrl #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_mac_addr   (req_mac_addr),
      .req_query_id   (req_query_id),
      .req_link_mtu   (req_link_mtu),
      .req_specs_word (req_specs_word),
      .res_valid      (res_valid),
      .res_take       (res_take),
      .res            (res)
   );

   // The output register frees up in the same cycle that its transfer completes.
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_found_id    = rsp_ff.entry.id;
   assign rsp_found_mac   = rsp_ff.entry.mac;
   assign rsp_found_mtu   = rsp_ff.entry.mtu;
   assign rsp_found_specs = rsp_ff.entry.specs;

endmodule

### hdl/mkn_entry_ram.sv
module mkn_entry_ram
   import mkn_pkg::*;
#(
   parameter int DEPTH = NODE_SLOTS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mkn_scan_ctrl.sv
module mkn_scan_ctrl
   import mkn_pkg::*;
#(
   parameter int NODE_SLOTS = NODE_SLOTS_DEF,
   localparam int AW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1,
   localparam int CW = $clog2(NODE_SLOTS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [MAC_W-1:0]   req_mac_addr,
   input  logic [ID_W-1:0]    req_query_id,
   input  logic [MTU_W-1:0]   req_link_mtu,
   input  logic [SPECS_W-1:0] req_specs_word,
   output logic               res_valid,
   input  logic               res_take,
   output result_type         res
);

   seq_state_type      state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [MAC_W-1:0]   mac_ff, mac_in;
   logic [ID_W-1:0]    qid_ff, qid_in;
   logic [MTU_W-1:0]   mtu_ff, mtu_in;
   logic [SPECS_W-1:0] specs_ff, specs_in;
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   result_type         res_ff, res_in;

   logic               wr_en;
   entry_type          wr_data;
   logic               rd_en;
   entry_type          rd_data;
   logic               key_is_mac;
   logic [MAC_W-1:0]   key_a;
   logic [MAC_W-1:0]   key_b;
   logic               hit;
   logic               more;

   mkn_entry_ram #(
      .DEPTH (NODE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // One equality compare serves both keys; an id is zero-extended to MAC width.
   assign key_is_mac = (cmd_ff != CMD_LOOKUP_ID);
   assign key_a      = key_is_mac ? rd_data.mac : MAC_W'(rd_data.id);
   assign key_b      = key_is_mac ? mac_ff : MAC_W'(qid_ff);
   assign hit        = pend_ff && (key_a == key_b);
   assign more       = (rd_idx_ff < fill_ff);

   assign wr_data = '{id: next_id_ff, mac: mac_ff, mtu: mtu_ff, specs: specs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         pend_ff    <= 1'b0;
         fill_ff    <= '0;
         next_id_ff <= ID_FIRST;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         fill_ff    <= fill_in;
         next_id_ff <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      mac_ff    <= mac_in;
      qid_ff    <= qid_in;
      mtu_ff    <= mtu_in;
      specs_ff  <= specs_in;
      rd_idx_ff <= rd_idx_in;
      res_ff    <= res_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      mac_in     = mac_ff;
      qid_in     = qid_ff;
      mtu_in     = mtu_ff;
      specs_in   = specs_ff;
      rd_idx_in  = rd_idx_ff;
      pend_in    = 1'b0;
      fill_in    = fill_ff;
      next_id_in = next_id_ff;
      res_in     = res_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;

      case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = req_cmd;
               mac_in    = req_mac_addr;
               qid_in    = req_query_id;
               mtu_in    = req_link_mtu;
               specs_in  = req_specs_word;
               rd_idx_in = '0;
               case (req_cmd)
                  CMD_REGISTER, CMD_LOOKUP_MAC, CMD_LOOKUP_ID: begin
                     state_in = SEQ_SCAN;
                  end
                  default: begin
                     res_in   = '{status: ST_NOT_FOUND, entry: '0};
                     state_in = SEQ_DONE;
                  end
               endcase
            end
         end

         SEQ_SCAN: begin
            // Reads are issued one slot ahead of the compare.
            if (hit) begin
               res_in.status = (cmd_ff == CMD_REGISTER) ? ST_EXISTS : ST_OK;
               res_in.entry  = rd_data;
               state_in      = SEQ_DONE;
            end else if (more) begin
               rd_en     = 1'b1;
               pend_in   = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
            end else if (cmd_ff == CMD_REGISTER) begin
               if (fill_ff == CW'(NODE_SLOTS)) begin
                  res_in   = '{status: ST_FULL, entry: '0};
                  state_in = SEQ_DONE;
               end else begin
                  state_in = SEQ_WRITE;
               end
            end else begin
               res_in   = '{status: ST_NOT_FOUND, entry: '0};
               state_in = SEQ_DONE;
            end
         end

         SEQ_WRITE: begin
            // Slots fill in order and are never freed, so the fill count is the free slot.
            wr_en      = 1'b1;
            fill_in    = fill_ff + CW'(1);
            next_id_in = next_id_ff + ID_W'(1);
            res_in     = '{status: ST_OK, entry: wr_data};
            state_in   = SEQ_DONE;
         end

         SEQ_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(NODE_SLOTS))
      else $error("fill count exceeds the slot count");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (fill_ff < CW'(NODE_SLOTS)))
      else $error("entry written into a full table");

   a_id_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      next_id_ff == (ID_W'(fill_ff) + ID_FIRST))
      else $error("next node id out of step with the fill count");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != SEQ_IDLE))
      else $error("sequencer stayed idle after a request transfer");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_idx_ff < fill_ff))
      else $error("read of a slot that was never written");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import mkn_pkg::*;

   localparam int SLOTS = NODE_SLOTS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   // The slowest answer is a hit in the last slot, a miss on a full table or a last-slot fill.
   localparam int SETTLE_CYCLES = SLOTS + 12;
   localparam int MAX_PRINTED = 40;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [MAC_W-1:0]    req_mac_addr = '0;
   logic [ID_W-1:0]     req_query_id = '0;
   logic [MTU_W-1:0]    req_link_mtu = '0;
   logic [SPECS_W-1:0]  req_specs_word = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_found_id;
   logic [MAC_W-1:0]    rsp_found_mac;
   logic [MTU_W-1:0]    rsp_found_mtu;
   logic [SPECS_W-1:0]  rsp_found_specs;

   // Shadow copy of the node table, updated as each command is issued.
   logic              node_live [SLOTS] = '{default: 1'b0};
   entry_type         node_entry [SLOTS];
   logic [ID_W-1:0]   next_node_id = ID_FIRST;
   result_type        pending_rsp [$];

   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;
   int error_count = 0;
   int cmds_sent = 0;
   int status_seen [4] = '{default: 0};

   mac_keyed_node_table u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_mac_addr    (req_mac_addr),
      .req_query_id    (req_query_id),
      .req_link_mtu    (req_link_mtu),
      .req_specs_word  (req_specs_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_id    (rsp_found_id),
      .rsp_found_mac   (rsp_found_mac),
      .rsp_found_mtu   (rsp_found_mtu),
      .rsp_found_specs (rsp_found_specs)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_rsp.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Applies one command to the shadow table and returns the answer it must produce.
   function automatic result_type apply_node_cmd(logic [CMD_W-1:0] cmd,
         logic [MAC_W-1:0] mac, logic [ID_W-1:0] qid, logic [MTU_W-1:0] mtu,
         logic [SPECS_W-1:0] specs);
      result_type res;
      int hit;
      int open_slot;
      res = '0;
      res.status = ST_NOT_FOUND;
      hit = -1;
      open_slot = -1;
      // Walk downward so that the lowest matching and lowest free slot win.
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (node_live[s]) begin
            if (cmd == CMD_LOOKUP_ID ? node_entry[s].id == qid : node_entry[s].mac == mac)
               hit = s;
         end else begin
            open_slot = s;
         end
      end
      case (cmd)
         CMD_REGISTER: begin
            if (hit >= 0) begin
               res.status = ST_EXISTS;
               res.entry = node_entry[hit];
            end else if (open_slot < 0) begin
               res.status = ST_FULL;
            end else begin
               node_live[open_slot] = 1'b1;
               node_entry[open_slot] = '{id: next_node_id, mac: mac, mtu: mtu, specs: specs};
               next_node_id++;
               res.status = ST_OK;
               res.entry = node_entry[open_slot];
            end
         end
         CMD_LOOKUP_MAC, CMD_LOOKUP_ID: begin
            if (hit >= 0) begin
               res.status = ST_OK;
               res.entry = node_entry[hit];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [MAC_W-1:0] pick_stored_mac();
      int live_slots [$];
      for (int s = 0; s < SLOTS; s++)
         if (node_live[s]) live_slots.push_back(s);
      if (live_slots.size() == 0) return rand_mac();
      return node_entry[live_slots[$urandom_range(0, live_slots.size() - 1)]].mac;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // The expectation is queued when the command is presented; commands complete in order.
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [MAC_W-1:0] mac,
         logic [ID_W-1:0] qid, logic [MTU_W-1:0] mtu, logic [SPECS_W-1:0] specs);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_cmd <= cmd;
      req_mac_addr <= mac;
      req_query_id <= qid;
      req_link_mtu <= mtu;
      req_specs_word <= specs;
      req_valid <= 1'b1;
      pending_rsp.push_back(apply_node_cmd(cmd, mac, qid, mtu, specs));
      cmds_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result status", 64'(rsp_status), '0);
         end else begin
            want = pending_rsp.pop_front();
            status_seen[int'(want.status)]++;
            if (rsp_status != want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_found_id != want.entry.id)
               report_mismatch("found_id", 64'(rsp_found_id), 64'(want.entry.id));
            if (rsp_found_mac != want.entry.mac)
               report_mismatch("found_mac", 64'(rsp_found_mac), 64'(want.entry.mac));
            if (rsp_found_mtu != want.entry.mtu)
               report_mismatch("found_mtu", 64'(rsp_found_mtu), 64'(want.entry.mtu));
            if (rsp_found_specs != want.entry.specs)
               report_mismatch("found_specs", rsp_found_specs, want.entry.specs);
         end
      end
   end

   task automatic test_empty_table();
      send_cmd(CMD_LOOKUP_MAC, '0, '0, '0, '0);
      send_cmd(CMD_LOOKUP_ID, '0, '0, '0, '0);
      send_cmd(CMD_LOOKUP_ID, '1, ID_FIRST, '0, '0);
      send_cmd(CMD_UNUSED, '0, '0, '0, '0);
   endtask

   task automatic test_register_extremes();
      send_cmd(CMD_REGISTER, '0, '0, '0, '0);
      send_cmd(CMD_REGISTER, '1, '1, '1, '1);
      // A second registration of a known MAC must return the stored entry untouched.
      send_cmd(CMD_REGISTER, '0, '1, 16'h5dc, 64'h0123_4567_89ab_cdef);
      send_cmd(CMD_LOOKUP_MAC, '1, '0, '0, '0);
      send_cmd(CMD_LOOKUP_MAC, '0, '1, '1, '1);
      send_cmd(CMD_LOOKUP_ID, '0, ID_FIRST + ID_W'(1), '0, '0);
      send_cmd(CMD_LOOKUP_ID, '1, ID_FIRST, '1, '1);
      send_cmd(CMD_LOOKUP_ID, '0, '0, '0, '0);
      send_cmd(CMD_LOOKUP_ID, '0, '1, '0, '0);
      send_cmd(CMD_LOOKUP_MAC, 48'h1, '0, '0, '0);
      send_cmd(CMD_UNUSED, '1, '1, '1, '1);
   endtask

   task automatic test_table_full();
      repeat (SLOTS + 2)
         send_cmd(CMD_REGISTER, rand_mac(), 16'($urandom), 16'($urandom),
                  {$urandom, $urandom});
      send_cmd(CMD_LOOKUP_ID, '0, next_node_id - 1'b1, '0, '0);
      send_cmd(CMD_LOOKUP_ID, '0, next_node_id, '0, '0);
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int count);
      int pick;
      logic [CMD_W-1:0]   cmd;
      logic [MAC_W-1:0]   mac;
      logic [ID_W-1:0]    qid;
      send_gap_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         mac = rand_mac();
         qid = 16'($urandom);
         if (pick < 28) begin
            cmd = CMD_LOOKUP_MAC;
            mac = pick_stored_mac();
         end else if (pick < 38) begin
            cmd = CMD_LOOKUP_MAC;
         end else if (pick < 46) begin
            // One flipped bit away from a stored MAC.
            cmd = CMD_LOOKUP_MAC;
            mac = pick_stored_mac() ^ (48'd1 << $urandom_range(0, MAC_W - 1));
         end else if (pick < 66) begin
            cmd = CMD_LOOKUP_ID;
            qid = 16'($urandom_range(0, int'(next_node_id) + 1));
         end else if (pick < 72) begin
            cmd = CMD_LOOKUP_ID;
         end else if (pick < 86) begin
            cmd = CMD_REGISTER;
            mac = pick_stored_mac();
         end else if (pick < 92) begin
            // A fresh MAC takes a slot until the table fills.
            cmd = CMD_REGISTER;
         end else begin
            cmd = CMD_UNUSED;
         end
         send_cmd(cmd, mac, qid, 16'($urandom), {$urandom, $urandom});
      end
   endtask

   initial begin
      send_gap_pct = 18;
      recv_stall_pct = 59;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_register_extremes();
      test_random_traffic(18, 59, 430);
      wait_for_results();
      test_table_full();
      test_random_traffic(59, 18, 430);
      wait_for_results();
      test_random_traffic(0, 0, 450);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d commands: %0d ok, %0d already present, %0d table full, %0d not found.",
               cmds_sent, status_seen[ST_OK], status_seen[ST_EXISTS], status_seen[ST_FULL],
               status_seen[ST_NOT_FOUND]);
      $display("Traffic used three stall mixes on both sides; %0d mismatches in %0d cycles.",
               error_count, cycle_count);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### sim.f
hdl/mkn_pkg.sv
hdl/mkn_entry_ram.sv
hdl/mkn_scan_ctrl.sv
hdl/mac_keyed_node_table.sv
tb/tb.sv
